// ===== design/pip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_pkg
// Shared types and constants of the point-in-polygon test block.
// ----------------------------------------------------------------------------
package pip_pkg;

   // defaults of the top-level parameters
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_BITS_DEF   = 16;

   // fixed field widths
   localparam int INDEX_W    = 6;
   localparam int COUNT_W    = 7;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // fewest vertices that form a polygon
   localparam int MIN_VERTICES = 3;

   // request kinds carried in tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // register index, taken from address bit 2
   localparam logic REG_VERTEX_COUNT = 1'b0;

   // query sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_WAIT,
      ST_DONE
   } pip_state_type;

   // tag that travels with each vertex memory read
   typedef struct packed {
      logic valid;   // a read was issued
      logic prime;   // closing vertex of the polygon, no edge yet
      logic last;    // final vertex of the walk
   } pip_rd_ctl_type;

endpackage

// ===== design/pip_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/pip_edge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pip_edge
// Edge crossing pipeline: takes one vertex per cycle from the vertex memory,
// forms the edge to the previous vertex and toggles the even-odd parity.
// ----------------------------------------------------------------------------
module pip_edge #(
   parameter int COORD_BITS = pip_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  pip_pkg::pip_rd_ctl_type      rd_ctl,
   input  logic signed [COORD_BITS-1:0] rd_x,
   input  logic signed [COORD_BITS-1:0] rd_y,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output logic                         done,
   output logic                         inside_flag
);
   import pip_pkg::*;

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   pip_rd_ctl_type r_ctl_ff;

   logic signed [COORD_BITS-1:0] prev_x_ff, prev_y_ff;

   // stage a: differences
   logic                 a_valid_ff, a_last_ff, a_cross_ff;
   logic signed [DW-1:0] a_dy_ff, a_dx_ff, a_ddx_ff, a_ddy_ff;
   logic                 a_edge, a_cross;

   // stage b: products
   logic                 b_valid_ff, b_last_ff, b_cross_ff, b_pos_ff;
   logic signed [PW-1:0] b_p1_ff, b_p2_ff;

   logic parity_ff, parity_in;
   logic toggle, left;

   // tag lines up with the registered memory data
   always_ff @(posedge clock) begin
      if (reset) begin
         r_ctl_ff <= '0;
      end else begin
         r_ctl_ff <= rd_ctl;
      end
   end

   // previous vertex is the far end of the next edge
   always_ff @(posedge clock) begin
      if (r_ctl_ff.valid) begin
         prev_x_ff <= rd_x;
         prev_y_ff <= rd_y;
      end
   end

   // edge from previous vertex j to current vertex i straddles the point's y
   assign a_edge  = r_ctl_ff.valid && !r_ctl_ff.prime;
   assign a_cross = (rd_y > py) != (prev_y_ff > py);

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_edge;
      end
   end

   always_ff @(posedge clock) begin
      a_last_ff  <= r_ctl_ff.last;
      a_cross_ff <= a_cross;
      a_dy_ff    <= DW'(prev_y_ff) - DW'(rd_y);
      a_dx_ff    <= DW'(prev_x_ff) - DW'(rd_x);
      a_ddx_ff   <= DW'(px) - DW'(rd_x);
      a_ddy_ff   <= DW'(py) - DW'(rd_y);
   end

   // cross products of the crossing test
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      b_last_ff  <= a_last_ff;
      b_cross_ff <= a_cross_ff;
      b_pos_ff   <= !a_dy_ff[DW-1];
      b_p1_ff    <= PW'(a_ddx_ff) * PW'(a_dy_ff);
      b_p2_ff    <= PW'(a_dx_ff) * PW'(a_ddy_ff);
   end

   // point left of the crossing; the compare flips with the sign of dy
   assign left   = b_pos_ff ? (b_p1_ff < b_p2_ff) : (b_p2_ff < b_p1_ff);
   assign toggle = b_valid_ff && b_cross_ff && left;

   always_comb begin
      parity_in = parity_ff ^ toggle;
      if (start) begin
         parity_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= 1'b0;
      end else begin
         parity_ff <= parity_in;
      end
   end

   assign done        = b_valid_ff && b_last_ff;
   assign inside_flag = parity_ff ^ toggle;

endmodule

// ===== design/point_in_polygon_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_in_polygon_test
// Even-odd ray-casting test of a point against a polygon held in a vertex
// memory, with an exact cross-multiply crossing test.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser is the request kind (0 vertex write, 1 query), tdata
//   carries vertex_index, coord_x and coord_y. A vertex write stores one
//   vertex and gives no response; a slot at or beyond MAX_VERTICES is
//   dropped.
//   rsp channel: one response per query, tdata bit 0 is inside_res.
//   csr port: vertex_count at byte address 0; the user must write it only
//   while idle; the block does not enforce this. Counts above
//   MAX_VERTICES act as MAX_VERTICES.
// Query and write flow: a query over n vertices (n >= 3) reads n + 1
//   vertices, one per cycle, from the single read port of the vertex memory
//   and drains the crossing pipeline; the next request is taken in the same
//   cycle as the response becomes valid. With fewer than three vertices the
//   response (outside) comes without a read. Writes go every cycle while idle.
// Reset clears the sequencer, vertex_count and the response register; the
// vertex memory keeps its contents and must be written before use.
// A stalled receiver holds the response in its output register; the next
// request is still taken, and a later query waits before handing over.
// ----------------------------------------------------------------------------
module point_in_polygon_test #(
   parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF,
   parameter int COORD_BITS   = pip_pkg::COORD_BITS_DEF,
   localparam int REQ_DATA_W  = ((pip_pkg::INDEX_W + 2 * COORD_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = opcode
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // request: tdata = vertex_index, coord_x, coord_y (lowest bit up)
   input  logic [REQ_DATA_W-1:0]             req_tdata,
   input  logic                              req_tuser,
   // response: tdata = inside_res
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pip_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // register port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pip_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [pip_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [pip_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import pip_pkg::*;

   localparam int AW = $clog2(MAX_VERTICES);
   localparam int NW = ($clog2(MAX_VERTICES + 1) > COUNT_W) ?
                       $clog2(MAX_VERTICES + 1) : COUNT_W;
   localparam int VW = 2 * COORD_BITS;

   pip_state_type state_ff, state_in;

   logic [COUNT_W-1:0]           count_ff;
   logic [NW-1:0]                n_eff, n_last;
   logic [AW-1:0]                idx_ff, idx_in;
   logic                         first_ff, first_in;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                         result_ff, result_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_data_ff;
   logic                         load_rsp;

   logic                         req_accept, is_query, short_poly, idx_last;
   logic [INDEX_W-1:0]           req_index;
   logic signed [COORD_BITS-1:0] req_x, req_y;

   logic                         wr_en, rd_en;
   logic [AW-1:0]                rd_addr;
   logic [VW-1:0]                rd_data;
   pip_rd_ctl_type               rd_ctl;
   logic                         edge_done, edge_inside;

   // request fields
   assign req_index  = req_tdata[INDEX_W-1:0];
   assign req_x      = req_tdata[INDEX_W +: COORD_BITS];
   assign req_y      = req_tdata[INDEX_W + COORD_BITS +: COORD_BITS];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign is_query   = (req_tuser == OP_QUERY);

   // register port
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_VERTEX_COUNT) ? CSR_DATA_W'(count_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_VERTEX_COUNT) begin
         count_ff <= csr_pwdata[COUNT_W-1:0];
      end
   end

   // vertices in use, clipped to the memory depth
   assign n_eff = (NW'(count_ff) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(count_ff);
   assign n_last     = n_eff - NW'(1);
   assign short_poly = n_eff < NW'(MIN_VERTICES);
   assign idx_last   = (NW'(idx_ff) == n_last);

   // vertex memory: x in the low half, y in the high half
   assign wr_en   = req_accept && (req_tuser == OP_WRITE) &&
                    (32'(req_index) < 32'(MAX_VERTICES));
   assign rd_en   = (state_ff == ST_READ);
   assign rd_addr = first_ff ? AW'(n_last) : idx_ff;

   assign rd_ctl.valid = rd_en;
   assign rd_ctl.prime = first_ff;
   assign rd_ctl.last  = !first_ff && idx_last;

   pip_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_index)),
      .wr_data ({req_y, req_x}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pip_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock       (clock),
      .reset       (reset),
      .start       (req_accept && is_query),
      .rd_ctl      (rd_ctl),
      .rd_x        (rd_data[COORD_BITS-1:0]),
      .rd_y        (rd_data[VW-1:COORD_BITS]),
      .px          (px_ff),
      .py          (py_ff),
      .done        (edge_done),
      .inside_flag (edge_inside)
   );

   // query sequencer
   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      first_in  = first_ff;
      result_in = result_ff;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept && is_query) begin
               idx_in   = '0;
               first_in = 1'b1;
               if (short_poly) begin
                  result_in = 1'b0;
                  state_in  = ST_DONE;
               end else begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            if (first_ff) begin
               first_in = 1'b0;
            end else if (idx_last) begin
               state_in = ST_WAIT;
            end else begin
               idx_in = idx_ff + AW'(1);
            end
         end
         ST_WAIT: begin
            if (edge_done) begin
               result_in = edge_inside;
               state_in  = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         first_ff <= first_in;
      end
   end

   // query point and result
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      if (req_accept && is_query) begin
         px_ff <= req_x;
         py_ff <= req_y;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_data_ff <= result_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(rsp_data_ff);

   // the edge pipeline finishes only while the sequencer waits for it
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      edge_done |-> state_ff == ST_WAIT)
      else $error("edge pipeline finished outside the wait state");

   // the read walk ends only by handing over to the pipeline drain
   a_read_exit: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |=> state_ff == ST_READ || state_ff == ST_WAIT)
      else $error("vertex walk left the read state unexpectedly");

   // a polygon of fewer than three vertices reports outside at once
   a_short_query: assert property (@(posedge clock) disable iff (reset)
      (req_accept && is_query && short_poly) |=> state_ff == ST_DONE && !result_ff)
      else $error("short polygon query not reported as outside");

endmodule
